@@ rtl/fbrop_pkg.sv @@
// Shared types and constants for the framebuffer pixel raster-op unit.
package fbrop_pkg;

  localparam int FB_DEPTH = 65536;
  localparam int FB_AW    = (FB_DEPTH > 1) ? $clog2(FB_DEPTH) : 1;

  localparam int X_W      = 10;
  localparam int Y_W      = 10;
  localparam int DIM_W    = 11;
  localparam int PIX_W    = 8;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W = 2;

  // x + y * width, widest case: 1023 + 1023 * 2047 fits in 21 bits.
  localparam int LIN_W    = 21;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_MODE    = 2'd2;

  localparam logic [MODE_W-1:0] MODE_COPY   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_XOR    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INVERT = 2'd2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = 11'd320;
  localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = 11'd200;
  localparam logic [MODE_W-1:0] RST_DRAW_MODE    = MODE_COPY;

  typedef struct packed {
    logic             command;
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
    logic [PIX_W-1:0] pixel;
  } fbrop_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] read_data;
    logic             in_range;
  } fbrop_out_t;

endpackage

@@ rtl/framebuffer_pixel_raster_op.sv @@
// Top level of the framebuffer pixel raster-op unit: address, range check, memory RMW.
//
//  channel  | handshake              | payload                        | accepted when
//  ---------+------------------------+--------------------------------+---------------------
//  request  | start / busy           | in_item  (command, x, y, pixel)| start && !busy
//  result   | out_valid (strobe)     | out_item (read_data, in_range) | every out_valid cycle
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data            | cfg_valid && cfg_ready
//
// One request per cycle is sustained while not busy; the result strobes once the
// request has passed the address stage and the frame memory's registered read port.
// Writes land from stage B, after the read, and a one-deep forward covers a request
// that reads the byte the request ahead of it is writing.
// After reset a clearing pass zeroes all FB_DEPTH (65536) bytes of the frame memory,
// one byte a cycle; busy is high during it. Config writes are always taken.
// The receiver cannot stall: each result is shown for exactly one cycle.
module framebuffer_pixel_raster_op
  import fbrop_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 start,
  output logic                 busy,
  input  fbrop_in_t            in_item,

  output logic                 out_valid,
  output fbrop_out_t           out_item,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  // Configuration registers
  logic [DIM_W-1:0]  frame_width_r,  frame_width_nxt;
  logic [DIM_W-1:0]  frame_height_r, frame_height_nxt;
  logic [MODE_W-1:0] draw_mode_r,    draw_mode_nxt;

  // Clearing pass
  logic             clr_active_r, clr_active_nxt;
  logic [FB_AW-1:0] clr_cnt_r,    clr_cnt_nxt;

  // Address stage (A) and modify stage (B)
  logic             a_valid_r, a_valid_nxt;
  logic             a_ok_r;
  logic             a_cmd_r;
  logic [PIX_W-1:0] a_pix_r;
  logic [FB_AW-1:0] a_addr_r;

  logic             b_valid_r, b_valid_nxt;
  logic             b_ok_r;
  logic             b_cmd_r;
  logic [PIX_W-1:0] b_pix_r;
  logic [FB_AW-1:0] b_addr_r;

  // Forward of the byte being written while the next request reads it
  logic             fwd_hit_r, fwd_hit_nxt;
  logic [PIX_W-1:0] fwd_data_r;

  logic [PIX_W-1:0] frame_mem [FB_DEPTH];
  logic [PIX_W-1:0] rd_data_r;

  logic             accept;
  logic [LIN_W-1:0] lin_addr;
  logic             lin_ok;
  logic [PIX_W-1:0] old_pix;
  logic [PIX_W-1:0] new_pix;
  logic             rmw_we;
  logic             mem_we;
  logic [FB_AW-1:0] mem_waddr;
  logic [PIX_W-1:0] mem_wdata;

  assign cfg_ready = 1'b1;
  assign busy      = clr_active_r;
  assign accept    = start && !busy;

  // Config writes; unknown index is dropped
  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    draw_mode_nxt    = draw_mode_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_nxt  = cfg_data;
        REG_FRAME_HEIGHT: frame_height_nxt = cfg_data;
        REG_DRAW_MODE:    draw_mode_nxt    = cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the clear sweep until the last entry is written
  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_cnt_nxt    = clr_cnt_r;
    if (clr_active_r) begin
      if (clr_cnt_r == FB_AW'(FB_DEPTH - 1)) begin
        clr_active_nxt = 1'b0;
      end else begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
    end
  end

  // Linear address and range check for the incoming request
  assign lin_addr = LIN_W'(in_item.x) + LIN_W'(in_item.y) * LIN_W'(frame_width_r);
  assign lin_ok   = (DIM_W'(in_item.x) < frame_width_r) &&
                    (DIM_W'(in_item.y) < frame_height_r) &&
                    (lin_addr < LIN_W'(FB_DEPTH));

  assign a_valid_nxt = accept;
  assign b_valid_nxt = a_valid_r;

  // Stored byte as seen by the request in stage B
  assign old_pix = fwd_hit_r ? fwd_data_r : rd_data_r;

  always_comb begin
    case (draw_mode_r)
      MODE_COPY:   new_pix = b_pix_r;
      MODE_XOR:    new_pix = old_pix ^ b_pix_r;
      MODE_INVERT: new_pix = ~old_pix;
      default:     new_pix = old_pix;
    endcase
  end

  // Mode 3 leaves memory untouched
  assign rmw_we = b_valid_r && b_ok_r && (b_cmd_r == CMD_WRITE) &&
                  ((draw_mode_r == MODE_COPY) || (draw_mode_r == MODE_XOR) ||
                   (draw_mode_r == MODE_INVERT));

  assign mem_we    = clr_active_r || rmw_we;
  assign mem_waddr = clr_active_r ? clr_cnt_r : b_addr_r;
  assign mem_wdata = clr_active_r ? '0 : new_pix;

  // Request in A reads the byte that B writes at the same edge: forward it
  assign fwd_hit_nxt = rmw_we && a_valid_r && (a_addr_r == b_addr_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= frame_mem[a_addr_r];
  end

  // Payload registers
  always_ff @(posedge clk) begin
    a_ok_r     <= lin_ok;
    a_cmd_r    <= in_item.command;
    a_pix_r    <= in_item.pixel;
    a_addr_r   <= lin_addr[FB_AW-1:0];
    b_ok_r     <= a_ok_r;
    b_cmd_r    <= a_cmd_r;
    b_pix_r    <= a_pix_r;
    b_addr_r   <= a_addr_r;
    fwd_data_r <= new_pix;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
      draw_mode_r    <= RST_DRAW_MODE;
      clr_active_r   <= 1'b1;
      clr_cnt_r      <= '0;
      a_valid_r      <= 1'b0;
      b_valid_r      <= 1'b0;
      fwd_hit_r      <= 1'b0;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      draw_mode_r    <= draw_mode_nxt;
      clr_active_r   <= clr_active_nxt;
      clr_cnt_r      <= clr_cnt_nxt;
      a_valid_r      <= a_valid_nxt;
      b_valid_r      <= b_valid_nxt;
      fwd_hit_r      <= fwd_hit_nxt;
    end
  end

  // Result: stored byte only for an in-range read
  assign out_valid          = b_valid_r;
  assign out_item.read_data = (b_ok_r && (b_cmd_r == CMD_READ)) ? old_pix : '0;
  assign out_item.in_range  = b_ok_r;

endmodule
